// File: hw/rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rANS symbol decoder package
// Shared beat types, action codes, controller states and fixed widths.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int unsigned SYM_W     = 8;
  localparam int unsigned FREQ_W    = 13;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned ACTION_W  = 2;
  // Coder state width and renormalization bound are fixed by the format.
  localparam int unsigned STATE_W   = 32;
  localparam int unsigned LOW_BITS  = 16;
  localparam logic [STATE_W-1:0] LOW_BOUND = STATE_W'(1) << LOW_BITS;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SHIFT  = 2'd1,
    ACT_DECODE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_MUL,
    ST_ADD,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SYM_W-1:0]    symbol_index;
    logic [FREQ_W-1:0]   frequency;
    logic [WORD_W-1:0]   code_word;
    logic                word_valid;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_W-1:0] decoded_symbol;
    logic             symbol_valid;
    logic             word_consumed;
    logic             finished;
  } out_beat_t;

endpackage

// File: hw/rtl/rans_symbol_decoder_unit.sv
// ----------------------------------------------------------------------------
// rANS symbol decoder unit
// Table-driven rANS decoder with 16-bit renormalization and a memory-based
// cumulative frequency search.
// ----------------------------------------------------------------------------
// Usage: every input beat carries one action. A load writes one symbol
// frequency and its cumulative start into the two on-chip tables; symbols are
// loaded in ascending order from symbol zero. A shift moves one 16-bit word of
// the initial coder state in from the low end. A decode searches the
// cumulative table for the symbol owning the current slot, updates the state
// and takes the offered code word when the state drops below 2^16.
// Every input beat produces exactly one output beat, in order.
// Both channels use valid/ready. The unit works on one beat at a time: a
// load, a shift or a finished decode reaches the output register from the
// dispatch state once that register is free; a symbol decode passes through
// dispatch, a binary search with one cumulative-table read per step, then
// the multiply, the add and the renormalization in the finish state.
// The unit returns to idle before it accepts the next beat.
// Reset clears the coder state, the running total and the control logic; the
// tables are undefined until loaded. When the receiver stalls, the result
// waits in the output register and the next beat is still accepted; its
// result is held back (without side effects) until the register frees up.
// ----------------------------------------------------------------------------
module rans_symbol_decoder_unit
  import rsd_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned SCALE_BITS   = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int unsigned IDX_W  = $clog2(SYMBOL_COUNT);
  localparam int unsigned CNT_W  = $clog2(SYMBOL_COUNT + 1);
  localparam int unsigned HI_W   = STATE_W - SCALE_BITS;
  localparam int unsigned PROD_W = FREQ_W + HI_W;
  localparam int unsigned CMP_W  = (SCALE_BITS > FREQ_W) ? SCALE_BITS : FREQ_W;
  localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(SYMBOL_COUNT);

  // Table memories, one write and one registered read port each.
  logic [FREQ_W-1:0] freq_mem [SYMBOL_COUNT];
  logic [FREQ_W-1:0] cum_mem  [SYMBOL_COUNT];

  state_e state_q, state_d;

  in_beat_t          item_q;
  logic [STATE_W-1:0] coder_q, coder_d;
  logic [FREQ_W-1:0]  running_q, running_d;
  logic [CNT_W-1:0]   first_q, first_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   sym_q, sym_d;
  logic [STATE_W-1:0] prod_q;
  logic [FREQ_W-1:0]  cum_sym_q;
  logic [STATE_W-1:0] calc_q;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_data_q, out_data_d;

  logic [FREQ_W-1:0] freq_rd_q, cum_rd_q;
  logic              mem_we, cum_re, freq_re;
  logic [IDX_W-1:0]  mem_waddr, cum_raddr;
  logic [FREQ_W-1:0] wr_freq, wr_start;

  logic                 out_free, in_fire, load_in_range, decode_live;
  logic [SCALE_BITS-1:0] slot;
  logic [CNT_W-1:0]     half, probe_full, nfirst, ncount, sym_full;
  logic                 slot_ge;
  logic [HI_W-1:0]      state_hi;
  logic [PROD_W-1:0]    prod_full;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign slot          = coder_q[SCALE_BITS-1:0];
  assign load_in_range = ({1'b0, item_q.symbol_index} < SYM_LIMIT);
  assign decode_live   = (coder_q > LOW_BOUND);

  // One binary-search step: the read data is the cumulative start at the
  // probe issued in the previous cycle.
  assign half       = count_q >> 1;
  assign probe_full = first_q + half;
  assign slot_ge    = (CMP_W'(slot) >= CMP_W'(cum_rd_q));
  assign nfirst     = slot_ge ? (probe_full + CNT_W'(1)) : first_q;
  assign ncount     = slot_ge ? (count_q - half - CNT_W'(1)) : half;
  assign sym_full   = (nfirst == '0) ? '0 : (nfirst - CNT_W'(1));

  assign state_hi  = coder_q[STATE_W-1:SCALE_BITS];
  assign prod_full = freq_rd_q * state_hi;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (item_q.action == ACT_DECODE && decode_live) begin
          state_d = ST_SEARCH;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (ncount == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:    state_d = ST_ADD;
      ST_ADD:    state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    coder_d     = coder_q;
    running_d   = running_q;
    first_d     = first_q;
    count_d     = count_q;
    sym_d       = sym_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = item_q.symbol_index[IDX_W-1:0];
    wr_freq     = item_q.frequency;
    wr_start    = (item_q.symbol_index == '0) ? '0 : running_q;
    cum_re      = 1'b0;
    freq_re     = 1'b0;
    cum_raddr   = probe_full[IDX_W-1:0];
    case (state_q)
      ST_DISPATCH: begin
        if (item_q.action == ACT_DECODE && decode_live) begin
          // Start the search and issue the first probe right away.
          first_d   = '0;
          count_d   = CNT_FULL;
          cum_re    = 1'b1;
          cum_raddr = IDX_W'(SYMBOL_COUNT / 2);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          case (item_q.action)
            ACT_LOAD: begin
              if (load_in_range) begin
                mem_we    = 1'b1;
                running_d = wr_start + wr_freq;
              end
            end
            ACT_SHIFT: begin
              if (item_q.word_valid) begin
                coder_d                  = {coder_q[STATE_W-LOW_BITS-1:0], item_q.code_word};
                out_data_d.word_consumed = 1'b1;
              end
            end
            ACT_DECODE: out_data_d.finished = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        first_d = nfirst;
        count_d = ncount;
        cum_re  = 1'b1;
        if (ncount == '0) begin
          sym_d     = sym_full[IDX_W-1:0];
          cum_raddr = sym_full[IDX_W-1:0];
          freq_re   = 1'b1;
        end else begin
          cum_raddr = IDX_W'(nfirst + (ncount >> 1));
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_data_d                = '0;
          out_data_d.decoded_symbol = SYM_W'(sym_q);
          out_data_d.symbol_valid   = 1'b1;
          coder_d                   = calc_q;
          if (calc_q < LOW_BOUND && item_q.word_valid) begin
            coder_d                  = {calc_q[STATE_W-LOW_BITS-1:0], item_q.code_word};
            out_data_d.word_consumed = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Table memories.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      freq_mem[mem_waddr] <= wr_freq;
      cum_mem[mem_waddr]  <= wr_start;
    end
    if (cum_re) begin
      cum_rd_q <= cum_mem[cum_raddr];
    end
    if (freq_re) begin
      freq_rd_q <= freq_mem[cum_raddr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_MUL) begin
      prod_q    <= STATE_W'(prod_full);
      cum_sym_q <= cum_rd_q;
    end
    if (state_q == ST_ADD) begin
      calc_q <= prod_q + STATE_W'(slot) - STATE_W'(cum_sym_q);
    end
    first_q    <= first_d;
    count_q    <= count_d;
    sym_q      <= sym_d;
    out_data_q <= out_data_d;
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      coder_q     <= '0;
      running_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      coder_q     <= coder_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The search never runs with an empty range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> count_q != '0)
    else $error("search entered with empty range");

  // Table reads stay inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cum_re || freq_re) |-> ({1'b0, cum_raddr} < (IDX_W + 1)'(SYMBOL_COUNT)))
    else $error("table read out of range");

  // A finished report never carries a symbol or a consumed word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.finished |->
      !out_data_o.symbol_valid && !out_data_o.word_consumed)
    else $error("finished beat carries data");

  // Once accepted, a beat holds off the next one until its result is queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second beat accepted while busy");

endmodule
